### rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic real-root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEFF_W       = 32;
  localparam int SQ_BITS       = 33;          // floor sqrt of D (< 2^66) fits 33 bits
  localparam int DISC_W        = 2 * SQ_BITS;
  localparam int REM_W         = SQ_BITS + 2;
  localparam int DEN_W         = 34;          // max(2|a|, sqrt(D)+|b|)
  localparam int QUO_W         = 33;          // quotient bits computed before clamp
  localparam int MAG_W         = 34;          // numerator magnitude before scaling
  localparam int SGN_W         = MAG_W + 1;

  typedef enum logic [2:0] {
    RC_NONE   = 3'd0,
    RC_LINEAR = 3'd1,
    RC_DOUBLE = 3'd2,
    RC_TWO    = 3'd3,
    RC_DEGEN  = 3'd4
  } root_case_t;

  // sideband carried alongside the discriminant and sqrt stages
  typedef struct packed {
    root_case_t          kase;
    logic                mode;
    logic                anz;
    logic                bnz;
    logic                cnz;
    logic                sa;
    logic                sb;
    logic                sc;
    logic [COEFF_W-1:0]  ma;
    logic [COEFF_W-1:0]  mb;
    logic [COEFF_W-1:0]  mc;
  } side_t;

  function automatic logic [COEFF_W-1:0] mag32(logic signed [COEFF_W-1:0] x);
    return x[COEFF_W-1] ? COEFF_W'(-x) : COEFF_W'(x);
  endfunction

endpackage

### rtl/quadratic_root_solver_top.sv
// Throughput: one item per cycle while the skid entry is free; 33 one-bit sqrt
// stages and 33 one-bit divide stages per root lane set the depth, not the rate.
// A two-entry output (register plus skid) absorbs sink stalls.
// Reset (rst, synchronous) clears all valid bits and sets formula_mode to 1.
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Pipelined real-root solver for a*x^2+b*x+c=0 in signed fixed point.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // formula_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,       // coeff_a, coeff_b, coeff_c
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,       // root_first, root_second
  output logic [3:0]  m_tuser        // root_case[2:0], saturated
);
  import qrs_pkg::*;

  localparam int NUM_W    = MAG_W + FRAC_BITS;
  localparam int NSQ      = SQ_BITS;
  localparam int ST_SQ0   = 3;
  localparam int ST_SET   = ST_SQ0 + NSQ;
  localparam int ST_DV0   = ST_SET + 1;
  localparam int ST_OUT   = ST_DV0 + 1 + QUO_W;
  localparam int NST      = ST_OUT + 1;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
  } lane_set_t;

  typedef struct packed {
    logic [QUO_W-1:0] nlo;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             big;
  } lane_div_t;

  logic             formula_mode;
  logic             en;
  logic [NST-1:0]   vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      formula_mode <= 1'b1;
    end else if (cfg_wr_en) begin
      formula_mode <= cfg_wr_data;
    end
  end

  // valid chain, global advance while the skid entry is free
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  assign s_tready = en;

  // stage 0: capture
  logic signed [COEFF_W-1:0] a0, b0, c0;
  logic                      md0;

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= s_tdata[31:0];
      b0  <= s_tdata[63:32];
      c0  <= s_tdata[95:64];
      md0 <= formula_mode;
    end
  end

  // stage 1: products
  logic [2*COEFF_W-1:0] pbb1, pac1;
  side_t                side1;

  always_ff @(posedge clk) begin
    if (en) begin
      pbb1       <= mag32(b0) * mag32(b0);
      pac1       <= mag32(a0) * mag32(c0);
      side1.kase <= RC_NONE;
      side1.mode <= md0;
      side1.anz  <= (a0 != '0);
      side1.bnz  <= (b0 != '0);
      side1.cnz  <= (c0 != '0);
      side1.sa   <= a0[COEFF_W-1];
      side1.sb   <= b0[COEFF_W-1];
      side1.sc   <= c0[COEFF_W-1];
      side1.ma   <= mag32(a0);
      side1.mb   <= mag32(b0);
      side1.mc   <= mag32(c0);
    end
  end

  // stage 2: discriminant and case
  logic [SQ_BITS-1:0] sq_rt   [0:NSQ];
  logic [REM_W-1:0]   sq_rm   [0:NSQ];
  logic [DISC_W-1:0]  sq_d    [0:NSQ];
  side_t              sq_side [0:NSQ];

  logic [DISC_W-1:0] p66, q4;
  logic              neg_ac, gt, eq;
  logic [DISC_W-1:0] d2;
  root_case_t        kase2;
  side_t             side2;

  always_comb begin
    p66    = {2'b00, pbb1};
    q4     = {pac1, 2'b00};
    neg_ac = (side1.sa != side1.sc) && side1.cnz;
    gt     = p66 > q4;
    eq     = p66 == q4;
    if (neg_ac) begin
      d2 = p66 + q4;
    end else if (gt) begin
      d2 = p66 - q4;
    end else begin
      d2 = '0;
    end
    if (!side1.anz) begin
      kase2 = side1.bnz ? RC_LINEAR : RC_DEGEN;
    end else if (neg_ac || gt) begin
      kase2 = RC_TWO;
    end else if (eq) begin
      kase2 = RC_DOUBLE;
    end else begin
      kase2 = RC_NONE;
    end
    side2      = side1;
    side2.kase = kase2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d[0]    <= d2;
      sq_rt[0]   <= '0;
      sq_rm[0]   <= '0;
      sq_side[0] <= side2;
    end
  end

  // sqrt: one result bit per stage, digit recurrence
  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    logic [REM_W-1:0] rs, tr;
    logic             ge;
    assign rs = {sq_rm[j][REM_W-3:0], sq_d[j][2*(NSQ-1-j)+1 -: 2]};
    assign tr = {sq_rt[j], 2'b01};
    assign ge = rs >= tr;
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rm[j+1]   <= ge ? rs - tr : rs;
        sq_rt[j+1]   <= {sq_rt[j][SQ_BITS-2:0], ge};
        sq_d[j+1]    <= sq_d[j];
        sq_side[j+1] <= sq_side[j];
      end
    end
  end

  // setup: numerators, divisors and signs for both lanes
  side_t              sd;
  logic [SGN_W-1:0]   bx, b35, s35, n1, n2, m1, m2;
  logic [DEN_W-1:0]   mq, ma2;
  logic [MAG_W-1:0]   mc2;
  logic [MAG_W-1:0]   nm1, nm2;
  logic [DEN_W-1:0]   dn1, dn2;
  logic               ng1, ng2;
  lane_set_t          set1, set2;
  root_case_t         set_kase;

  always_comb begin
    sd  = sq_side[NSQ];
    bx  = {3'b000, sd.mb};
    b35 = sd.sb ? (SGN_W'(0) - bx) : bx;
    s35 = {2'b00, sq_rt[NSQ]};
    n1  = s35 - b35;
    n2  = SGN_W'(0) - b35 - s35;
    m1  = n1[SGN_W-1] ? (SGN_W'(0) - n1) : n1;
    m2  = n2[SGN_W-1] ? (SGN_W'(0) - n2) : n2;
    mq  = {1'b0, sq_rt[NSQ]} + {2'b00, sd.mb};
    ma2 = {1'b0, sd.ma, 1'b0};
    mc2 = {1'b0, sd.mc, 1'b0};
    nm1 = '0; dn1 = '0; ng1 = 1'b0;
    nm2 = '0; dn2 = '0; ng2 = 1'b0;
    case (sd.kase)
      RC_LINEAR: begin
        ng1 = (sd.sc == sd.sb) && sd.cnz;
        nm1 = {2'b00, sd.mc};
        dn1 = {2'b00, sd.mb};
      end
      RC_DOUBLE: begin
        ng1 = (sd.sb == sd.sa) && sd.bnz;
        nm1 = {2'b00, sd.mb};
        dn1 = ma2;
      end
      RC_TWO: begin
        if (!sd.mode) begin
          ng1 = (n1[SGN_W-1] != sd.sa) && (n1 != '0);
          nm1 = m1[MAG_W-1:0];
          dn1 = ma2;
          ng2 = (n2[SGN_W-1] != sd.sa) && (n2 != '0);
          nm2 = m2[MAG_W-1:0];
          dn2 = ma2;
        end else begin
          // q = -(b + sgn(b) sqrt(D)), negative exactly when b >= 0
          ng1 = (sd.sc != !sd.sb) && sd.cnz;
          nm1 = mc2;
          dn1 = mq;
          ng2 = (!sd.sb) != sd.sa;
          nm2 = mq;
          dn2 = ma2;
        end
      end
      default: begin
        nm1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      set1.num <= {nm1, {FRAC_BITS{1'b0}}};
      set1.den <= dn1;
      set1.neg <= ng1;
      set2.num <= {nm2, {FRAC_BITS{1'b0}}};
      set2.den <= dn2;
      set2.neg <= ng2;
      set_kase <= sd.kase;
    end
  end

  // divide: overflow precheck, then one quotient bit per stage
  lane_div_t  dv1  [0:QUO_W];
  lane_div_t  dv2  [0:QUO_W];
  root_case_t dv_k [0:QUO_W];

  function automatic lane_div_t div_init(lane_set_t s);
    lane_div_t r;
    r.nlo = s.num[QUO_W-1:0];
    r.den = s.den;
    r.big = (s.num >> QUO_W) >= NUM_W'(s.den);
    r.rem = DEN_W'(s.num >> QUO_W);
    r.quo = '0;
    r.neg = s.neg;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dv1[0]  <= div_init(set1);
      dv2[0]  <= div_init(set2);
      dv_k[0] <= set_kase;
    end
  end

  function automatic lane_div_t div_step(lane_div_t s, logic nbit);
    lane_div_t      r;
    logic [DEN_W:0] r2;
    logic           ge;
    r2    = {s.rem, nbit};
    ge    = r2 >= {1'b0, s.den};
    r     = s;
    r.rem = ge ? DEN_W'(r2 - {1'b0, s.den}) : DEN_W'(r2);
    r.quo = {s.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  for (genvar k = 0; k < QUO_W; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        dv1[k+1]  <= div_step(dv1[k], dv1[k].nlo[QUO_W-1-k]);
        dv2[k+1]  <= div_step(dv2[k], dv2[k].nlo[QUO_W-1-k]);
        dv_k[k+1] <= dv_k[k];
      end
    end
  end

  // final: sign, clamp, mask inactive lanes
  function automatic logic [COEFF_W:0] clamp(lane_div_t s);
    logic             sat;
    logic [COEFF_W-1:0] v;
    sat = s.big || (s.quo > (s.neg ? QUO_W'(33'h080000000) : QUO_W'(33'h07fffffff)));
    if (sat) begin
      v = s.neg ? 32'h80000000 : 32'h7fffffff;
    end else begin
      v = s.neg ? (32'd0 - s.quo[COEFF_W-1:0]) : s.quo[COEFF_W-1:0];
    end
    return {sat, v};
  endfunction

  logic [COEFF_W:0] cl1, cl2;
  logic             act1, act2;
  logic [63:0]      fin_data;
  logic [3:0]       fin_user;

  always_comb begin
    cl1  = clamp(dv1[QUO_W]);
    cl2  = clamp(dv2[QUO_W]);
    act1 = (dv_k[QUO_W] == RC_LINEAR) || (dv_k[QUO_W] == RC_DOUBLE) ||
           (dv_k[QUO_W] == RC_TWO);
    act2 = (dv_k[QUO_W] == RC_TWO);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_data[31:0]  <= act1 ? cl1[COEFF_W-1:0] : '0;
      fin_data[63:32] <= act2 ? cl2[COEFF_W-1:0] : '0;
      fin_user        <= {(act1 & cl1[COEFF_W]) | (act2 & cl2[COEFF_W]), dv_k[QUO_W]};
    end
  end

  // output register plus skid entry
  logic        ov, sv;
  logic [63:0] skid_data;
  logic [3:0]  skid_user;
  logic        emerge, take;

  assign en     = !sv;
  assign emerge = vld[ST_OUT] && en;
  assign take   = !ov || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (take) begin
      ov <= sv || emerge;
      sv <= 1'b0;
    end else if (emerge) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= sv ? skid_data : fin_data;
      m_tuser <= sv ? skid_user : fin_user;
    end else if (emerge) begin
      skid_data <= fin_data;
      skid_user <= fin_user;
    end
  end

  assign m_tvalid = ov;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid holds an item while output is empty");

  a_second_only_two: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[2:0] != RC_TWO)) |-> (m_tdata[63:32] == '0))
    else $error("second root set outside two-root case");

  a_no_root_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser[2:0] == RC_NONE) || (m_tuser[2:0] == RC_DEGEN)))
      |-> (m_tdata == '0 && !m_tuser[3]))
    else $error("roots or saturation reported with no root");

endmodule

### verif/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Watches the coefficient and root streams of the quadratic root solver,
// computes the expected roots of every accepted item and compares each
// returned item with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module qrs_checker
  import qrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [3:0]  m_tuser,
  output int          errors,
  output int          pending
);

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    logic [31:0] root_first;
    logic [31:0] root_second;
    root_case_t  kase;
    logic        saturated;
  } roots_t;

  roots_t expected_roots[$];
  logic   mode_shadow;

  function automatic longint abs64(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // truncating divide of magnitudes, sign applied, clamped to 32 bits
  function automatic longint clamp_div(bit neg, logic [127:0] num, logic [127:0] den,
                                       inout bit sat);
    logic [127:0] quo;
    logic [127:0] limit;
    quo   = num / den;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (quo > limit) begin
      sat = 1'b1;
      quo = limit;
    end
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic longint floor_sqrt(logic [127:0] d);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 34; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= d) r = t;
    end
    return longint'(r[63:0]);
  endfunction

  function automatic roots_t solve_roots(logic signed [31:0] a, logic signed [31:0] b,
                                         logic signed [31:0] c, logic mode);
    roots_t       res;
    longint       av, bv, cv, s, n1, n2, q2, r1, r2;
    logic [127:0] ma, mb, mc, p, q4, d;
    bit           sat, neg_ac;
    int           sgn;
    av = longint'(a); bv = longint'(b); cv = longint'(c);
    ma = 128'(abs64(av)); mb = 128'(abs64(bv)); mc = 128'(abs64(cv));
    r1 = 0; r2 = 0; sat = 0;
    if (av == 0) begin
      if (bv == 0) begin
        res.kase = RC_DEGEN;
      end else begin
        res.kase = RC_LINEAR;
        r1 = clamp_div((cv < 0) == (bv < 0) && cv != 0, mc << FB, mb, sat);
      end
    end else begin
      p      = mb * mb;
      q4     = (ma * mc) << 2;
      neg_ac = ((av < 0) != (cv < 0)) && cv != 0;
      if (neg_ac) begin
        d = p + q4; sgn = 1;
      end else begin
        sgn = (p > q4) ? 1 : (p == q4) ? 0 : -1;
        d   = (sgn > 0) ? p - q4 : '0;
      end
      if (sgn < 0) begin
        res.kase = RC_NONE;
      end else if (sgn == 0) begin
        res.kase = RC_DOUBLE;
        r1 = clamp_div((bv < 0) == (av < 0) && bv != 0, mb << FB, 2 * ma, sat);
      end else begin
        res.kase = RC_TWO;
        s = floor_sqrt(d);
        if (mode == 1'b0) begin
          n1 = s - bv;
          n2 = -bv - s;
          r1 = clamp_div((n1 < 0) != (av < 0) && n1 != 0, 128'(abs64(n1)) << FB, 2 * ma, sat);
          r2 = clamp_div((n2 < 0) != (av < 0) && n2 != 0, 128'(abs64(n2)) << FB, 2 * ma, sat);
        end else begin
          q2 = (bv >= 0) ? -(bv + s) : (s - bv);
          r1 = clamp_div((cv < 0) != (q2 < 0) && cv != 0, (2 * mc) << FB,
                         128'(abs64(q2)), sat);
          r2 = clamp_div((q2 < 0) != (av < 0), 128'(abs64(q2)) << FB, 2 * ma, sat);
        end
      end
    end
    res.root_first  = r1[31:0];
    res.root_second = r2[31:0];
    res.saturated   = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    roots_t exp_item;
    if (rst) begin
      mode_shadow <= 1'b1;
      errors      <= 0;
      expected_roots.delete();
      pending     <= 0;
    end else begin
      if (cfg_wr_en) mode_shadow <= cfg_wr_data;
      if (s_tvalid && s_tready)
        expected_roots.push_back(solve_roots(s_tdata[31:0], s_tdata[63:32],
                                             s_tdata[95:64], mode_shadow));
      if (m_tvalid && m_tready) begin
        if (expected_roots.size() == 0) begin
          if (errors < 10) $display("unexpected result item %h %h", m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          exp_item = expected_roots.pop_front();
          if (m_tdata[31:0] !== exp_item.root_first || m_tdata[63:32] !== exp_item.root_second
              || m_tuser[2:0] !== exp_item.kase || m_tuser[3] !== exp_item.saturated) begin
            if (errors < 10)
              $display("mismatch: exp r1=%h r2=%h case=%0d sat=%b got r1=%h r2=%h case=%0d sat=%b",
                       exp_item.root_first, exp_item.root_second, exp_item.kase,
                       exp_item.saturated, m_tdata[31:0], m_tdata[63:32], m_tuser[2:0],
                       m_tuser[3]);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_roots.size();
    end
  end

endmodule

### verif/tb_quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_top
// Drives coefficient triples through the solver in both formula modes with
// random gaps and output stalls; the checker predicts and compares roots.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_RANDOM       = 650;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;      // coeff_a, coeff_b, coeff_c
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;      // root_first, root_second
  logic [3:0]  m_tuser;      // root_case[2:0], saturated
  int          errors;
  int          pending;
  int          idle_cycles;
  bit          hold_req;
  bit          hold_done;

  quadratic_root_solver_top u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  qrs_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom;
    if (r < 75) return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
    return 32'($signed($urandom_range(0, 511)) - 256);
  endfunction

  // sink stalls, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_done = 1'b1;
      repeat (300) @(posedge clk);
    end else if ($urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(5, 30)) @(posedge clk);
    end else begin
      m_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_coeffs(logic [31:0] a, logic [31:0] b, logic [31:0] c, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain_and_set_mode(logic mode);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic directed_set();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_coeffs(32'h0, 32'h0, 32'h1234_5678, 0);          // degenerate
    send_coeffs(32'h0, 32'h0, 32'h0, 1);
    send_coeffs(32'h0, one, 32'hFFFE_0000, 0);            // linear
    send_coeffs(32'h0, 32'h0000_0001, 32'h7FFF_FFFF, 0);  // linear, clamps
    send_coeffs(32'h0, 32'h8000_0000, 32'h8000_0000, 2);
    send_coeffs(one, 32'h0, one, 0);                      // no real root
    send_coeffs(one, 32'h0002_0000, one, 0);              // double root
    send_coeffs(32'hFFFF_0000, 32'h0004_0000, 32'hFFFC_0000, 0);
    send_coeffs(one, 32'hFFFD_0000, 32'h0002_0000, 0);    // two roots
    send_coeffs(one, 32'h0, 32'hFFFC_0000, 0);            // zero b, two roots
    send_coeffs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_coeffs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    send_coeffs(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0001, 0);
    send_coeffs(32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send_coeffs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
    send_coeffs(32'h0000_0001, 32'h0000_0001, 32'h0, 0);  // zero c
  endtask

  task automatic random_set(int n);
    int          kind;
    logic [31:0] a, b, c;
    int          k;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_req = 1'b1;
      kind = $urandom_range(0, 99);
      a = rand_coeff(); b = rand_coeff(); c = rand_coeff();
      if (kind < 8) begin
        a = '0;
        if ($urandom_range(0, 3) == 0) b = '0;
      end else if (kind < 20) begin
        // b*b == 4*a*c exactly
        k = $urandom_range(1, 60000);
        a = ($urandom_range(0, 1)) ? k : -k;
        c = a;
        b = ($urandom_range(0, 1)) ? 2 * k : -2 * k;
      end
      send_coeffs(a, b, c, pick_gap());
    end
  endtask

  initial begin
    int wait_cycles;
    rst         = 1'b1;
    hold_req    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_set();
    random_set(N_RANDOM / 3);
    drain_and_set_mode(1'b0);
    directed_set();
    random_set(N_RANDOM / 3);
    drain_and_set_mode(1'b1);
    random_set(N_RANDOM / 3);

    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### quadratic_root_solver_top.f
rtl/qrs_pkg.sv
rtl/quadratic_root_solver_top.sv
verif/qrs_checker.sv
verif/tb_quadratic_root_solver_top.sv
